[sv/egbp_pkg.sv]
`default_nettype none

package egbp_pkg;

    // value field and stream geometry
    localparam int VALUE_WIDTH = 31;
    localparam int BYTE_BITS   = 8;
    localparam int CNT_W       = $clog2(BYTE_BITS);
    localparam int TAKE_W      = $clog2(BYTE_BITS + 1);
    localparam int LEN_W       = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W       = $clog2(VALUE_WIDTH);
    localparam int N_W         = $clog2(2 * VALUE_WIDTH);
    localparam int POS_W       = $clog2(2 * VALUE_WIDTH + BYTE_BITS);

    // item kinds on the kind port
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // command kinds handed from front to back
    typedef enum logic [1:0] {
        OP_ENCODE,
        OP_FLUSH,
        OP_ZERO
    } op_t;

    // classified command: code word length and value
    typedef struct packed {
        op_t                    op;
        logic [N_W-1:0]         nbits;
        logic [VALUE_WIDTH-1:0] value;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
        logic                 error;
    } result_t;

    // bit length of a value: index of the highest one plus one
    function automatic logic [LEN_W-1:0] bit_length(input logic [VALUE_WIDTH-1:0] v);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (v[i])
            begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[sv/elias_gamma_bit_packer_top.sv]
// flow: an accepted item is written into the command queue; the back end turns a zero or
//   flush command into its result as it takes it, and the result queue registers that result
//   before the result ports; a flush with no pending bits gives no result; an encode loads its
//   word, then moves up to a byte's worth of code bits per step and completes 0..8 bytes
// reset: rst_n asynchronous active low, empties both queues and the pending byte
`default_nettype none

module elias_gamma_bit_packer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             kind,
    input  wire logic [egbp_pkg::VALUE_WIDTH-1:0] value,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [egbp_pkg::BYTE_BITS-1:0]        out_byte,
    output logic                                  last,
    output logic                                  error
);

    logic              cmd_valid;
    logic              cmd_ready;
    egbp_pkg::cmd_t    cmd;
    logic              res_valid;
    logic              res_room;
    egbp_pkg::result_t res;

    // item intake and classification
    egbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // bit packing sequencer
    egbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_room  (res_room),
        .res       (res)
    );

    // result buffering
    egbp_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_room  (res_room),
        .res       (res),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last      (last),
        .error     (error)
    );

endmodule

`default_nettype wire

[sv/egbp_front.sv]
`default_nettype none

module egbp_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             kind,
    input  wire logic [egbp_pkg::VALUE_WIDTH-1:0] value,
    output logic                                  cmd_valid,
    input  wire logic                             cmd_ready,
    output egbp_pkg::cmd_t                        cmd
);

    egbp_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    egbp_pkg::cmd_t cls;
    logic           do_push, do_pop;
    logic [egbp_pkg::LEN_W-1:0] len;

    // classify the incoming item
    always_comb
    begin
        len       = egbp_pkg::bit_length(value);
        cls.value = value;
        cls.nbits = egbp_pkg::N_W'(2 * int'(len) - 1);
        if (kind == egbp_pkg::KIND_FLUSH)
        begin
            cls.op = egbp_pkg::OP_FLUSH;
        end
        else if (value == '0)
        begin
            cls.op = egbp_pkg::OP_ZERO;
        end
        else
        begin
            cls.op = egbp_pkg::OP_ENCODE;
        end
    end

    // two-entry command queue
    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // an encode command always carries an odd, nonzero code length
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.op == egbp_pkg::OP_ENCODE |-> cmd.nbits[0] && cmd.value != '0)
        else $error("encode command with bad code length");

endmodule

`default_nettype wire

[sv/egbp_back.sv]
`default_nettype none

module egbp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire egbp_pkg::cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_room,
    output egbp_pkg::result_t   res
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                                state_reg, state_next;
    logic [egbp_pkg::N_W-1:0]              n_reg, n_next;
    logic [egbp_pkg::VALUE_WIDTH-1:0]      v_reg, v_next;
    logic [egbp_pkg::BYTE_BITS-2:0]        pend_reg, pend_next;
    logic [egbp_pkg::CNT_W-1:0]            cnt_reg, cnt_next;

    logic [egbp_pkg::TAKE_W-1:0]           avail, take, c_sum;
    logic [egbp_pkg::POS_W-1:0]            top;
    logic [egbp_pkg::POS_W-1:0]            pos [egbp_pkg::BYTE_BITS];
    logic [egbp_pkg::BYTE_BITS-1:0]        step_byte;
    logic [egbp_pkg::N_W-1:0]              n_left;

    // one step: move up to a byte's worth of code bits into the pending byte
    always_comb
    begin
        avail = egbp_pkg::TAKE_W'(egbp_pkg::BYTE_BITS) - egbp_pkg::TAKE_W'(cnt_reg);
        take  = (n_reg < egbp_pkg::N_W'(avail)) ? egbp_pkg::TAKE_W'(n_reg) : avail;
        c_sum = egbp_pkg::TAKE_W'(cnt_reg) + take;
        top   = egbp_pkg::POS_W'(n_reg) - egbp_pkg::POS_W'(1) + egbp_pkg::POS_W'(cnt_reg);
        n_left = n_reg - egbp_pkg::N_W'(take);
        for (int i = 0; i < egbp_pkg::BYTE_BITS; i++)
        begin
            pos[i] = top - egbp_pkg::POS_W'(i);
            if (egbp_pkg::TAKE_W'(i) >= egbp_pkg::TAKE_W'(cnt_reg) &&
                egbp_pkg::TAKE_W'(i) < c_sum)
            begin
                step_byte[i] = (pos[i] < egbp_pkg::POS_W'(egbp_pkg::VALUE_WIDTH)) ?
                               v_reg[pos[i][egbp_pkg::IDX_W-1:0]] : 1'b0;
            end
            else if (i < egbp_pkg::BYTE_BITS - 1)
            begin
                step_byte[i] = pend_reg[i];
            end
            else
            begin
                step_byte[i] = 1'b0;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        v_next     = v_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && res_room)
                begin
                    cmd_ready = 1'b1;
                    case (cmd.op)
                        egbp_pkg::OP_ENCODE:
                        begin
                            n_next     = cmd.nbits;
                            v_next     = cmd.value;
                            state_next = S_RUN;
                        end
                        egbp_pkg::OP_FLUSH:
                        begin
                            if (cnt_reg != '0)
                            begin
                                res_valid    = 1'b1;
                                res.out_byte = {1'b0, pend_reg};
                                res.last     = 1'b1;
                                pend_next    = '0;
                                cnt_next     = '0;
                            end
                        end
                        egbp_pkg::OP_ZERO:
                        begin
                            res_valid = 1'b1;
                            res.last  = 1'b1;
                            res.error = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (res_room)
                begin
                    n_next = n_left;
                    if (c_sum == egbp_pkg::TAKE_W'(egbp_pkg::BYTE_BITS))
                    begin
                        res_valid    = 1'b1;
                        res.out_byte = step_byte;
                        res.last     = (n_left < egbp_pkg::N_W'(egbp_pkg::BYTE_BITS));
                        pend_next    = '0;
                        cnt_next     = '0;
                    end
                    else
                    begin
                        pend_next = step_byte[egbp_pkg::BYTE_BITS-2:0];
                        cnt_next  = c_sum[egbp_pkg::CNT_W-1:0];
                    end
                    if (n_left == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            v_reg     <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            v_reg     <= v_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
        end
    end

    // a running encode still has code bits left
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> n_reg != '0)
        else $error("encode running with no bits left");

    // results are only produced when the result queue has room
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_room)
        else $error("result produced without room");

    // an error result is a lone zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error |-> res.last && res.out_byte == '0 && state_reg == S_IDLE)
        else $error("malformed error result");

endmodule

`default_nettype wire

[sv/egbp_out_queue.sv]
`default_nettype none

module egbp_out_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           res_valid,
    output logic                                res_room,
    input  wire egbp_pkg::result_t              res,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [egbp_pkg::BYTE_BITS-1:0]      out_byte,
    output logic                                last,
    output logic                                error
);

    egbp_pkg::result_t q_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    // two-entry result queue
    assign res_room = (count_reg != 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = res_valid && res_room;
    assign do_pop   = pop && !empty;
    assign out_byte = q_reg[rd_ptr_reg].out_byte;
    assign last     = q_reg[rd_ptr_reg].last;
    assign error    = q_reg[rd_ptr_reg].error;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    // occupancy agrees with the pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3 && ((count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("result queue pointers out of step");

endmodule

`default_nettype wire
